### rtl/sac_pkg.sv
// Package for the set-associative cache tag/LRU controller.
// Holds the back-end state enum and the access-kind constants.
// No dependencies.
package sac_pkg;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_WRITE
    } back_state_t;

    // Access kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

endpackage

### rtl/sac_front.sv
// Front end: takes accesses and splits the address into set and tag.
// Holds a short queue of decoded items for the back end.
// Depends on sac_pkg.
module sac_front #(
    parameter int SET_BITS = 8,
    parameter int TAG_BITS = 19,
    parameter int OFF_BITS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                action,
    input  logic [31:0]         address,
    output logic                busy,
    output logic                q_valid,
    output logic                q_action,
    output logic [SET_BITS-1:0] q_set,
    output logic [TAG_BITS-1:0] q_tag,
    input  logic                q_pop
);

    // one-entry queue between front and back
    logic                full_reg, full_next;
    logic                act_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                take;

    assign busy    = full_reg;
    assign take    = start && !full_reg;
    assign q_valid = full_reg;
    assign q_action = act_reg;
    assign q_set   = set_reg;
    assign q_tag   = tag_reg;

    always_comb
    begin
        full_next = full_reg;
        if (q_pop)
        begin
            full_next = 1'b0;
        end
        if (take)
        begin
            full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            act_reg <= action;
            set_reg <= address[OFF_BITS +: SET_BITS];
            tag_reg <= address[31 -: TAG_BITS];
        end
    end

endmodule

### rtl/sac_back.sv
// Back end: reads one set's row, resolves hit/victim, writes the row back.
// Tag store is a memory; valid/dirty/age are memories gated by a clearing pass.
// Depends on sac_pkg.
module sac_back #(
    parameter int WAYS     = 8,
    parameter int SET_BITS = 8,
    parameter int TAG_BITS = 19,
    parameter int OFF_BITS = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  logic                    q_action,
    input  logic [SET_BITS-1:0]     q_set,
    input  logic [TAG_BITS-1:0]     q_tag,
    output logic                    q_pop,
    output logic                    done,
    output logic                    hit,
    output logic [$clog2(WAYS)-1:0] way,
    output logic                    write_back,
    output logic [31:0]             victim_address
);

    localparam int WB   = $clog2(WAYS);
    localparam int SETS = 1 << SET_BITS;

    typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;
    typedef logic [WAYS-1:0][WB-1:0]       age_row_t;

    // row memories, one row per set
    tag_row_t        tag_mem   [SETS];
    logic [WAYS-1:0] valid_mem [SETS];
    logic [WAYS-1:0] dirty_mem [SETS];
    age_row_t        age_mem   [SETS];

    sac_pkg::back_state_t state_reg, state_next;
    logic                clr_reg;
    logic [SET_BITS:0]   clr_cnt_reg;
    logic                act_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [TAG_BITS-1:0] tag_reg;
    tag_row_t            rd_tag_reg;
    logic [WAYS-1:0]     rd_valid_reg, rd_dirty_reg;
    age_row_t            rd_age_reg;

    // decision registers
    logic                hit_reg;
    logic [WB-1:0]       way_reg;
    logic                wb_reg;
    logic [31:0]         vaddr_reg;
    logic [WAYS-1:0]     nvalid_reg, ndirty_reg;
    age_row_t            nage_reg;
    logic                done_reg;

    // combinational decision
    logic                c_hit, c_found, c_zero;
    logic [WB-1:0]       c_hway, c_iway, c_zway, c_way;
    logic [WAYS-1:0]     c_valid, c_dirty;
    age_row_t            c_age;
    logic                c_wb;
    logic [31:0]         c_vaddr;
    logic [WB-1:0]       old_age;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sac_pkg::ST_IDLE:   if (q_valid && !clr_reg) state_next = sac_pkg::ST_READ;
            sac_pkg::ST_READ:   state_next = sac_pkg::ST_DECIDE;
            sac_pkg::ST_DECIDE: state_next = sac_pkg::ST_WRITE;
            sac_pkg::ST_WRITE:  state_next = sac_pkg::ST_IDLE;
            default:            state_next = sac_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop = 1'b0;
        unique case (state_reg)
            sac_pkg::ST_IDLE: q_pop = q_valid && !clr_reg;
            default:          q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sac_pkg::ST_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == sac_pkg::ST_DECIDE);
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (SET_BITS+1)'(SETS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    // capture the item
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            act_reg <= q_action;
            set_reg <= q_set;
            tag_reg <= q_tag;
        end
    end

    // registered row read
    always_ff @(posedge clk)
    begin
        if (state_reg == sac_pkg::ST_READ)
        begin
            rd_tag_reg   <= tag_mem[set_reg];
            rd_valid_reg <= valid_mem[set_reg];
            rd_dirty_reg <= dirty_mem[set_reg];
            rd_age_reg   <= age_mem[set_reg];
        end
    end

    // row writes: clearing pass or update
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            valid_mem[clr_cnt_reg[SET_BITS-1:0]] <= '0;
            dirty_mem[clr_cnt_reg[SET_BITS-1:0]] <= '0;
            age_mem[clr_cnt_reg[SET_BITS-1:0]]   <= '0;
        end
        else if (state_reg == sac_pkg::ST_WRITE)
        begin
            valid_mem[set_reg] <= nvalid_reg;
            dirty_mem[set_reg] <= ndirty_reg;
            age_mem[set_reg]   <= nage_reg;
            if (!hit_reg)
            begin
                tag_mem[set_reg][way_reg] <= tag_reg;
            end
        end
    end

    // hit search, first invalid, first zero age
    always_comb
    begin
        c_hit = 1'b0; c_found = 1'b0; c_zero = 1'b0;
        c_hway = '0; c_iway = '0; c_zway = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (rd_valid_reg[i] && rd_tag_reg[i] == tag_reg)
            begin
                c_hit = 1'b1; c_hway = WB'(i);
            end
            if (!rd_valid_reg[i])
            begin
                c_found = 1'b1; c_iway = WB'(i);
            end
            if (rd_age_reg[i] == '0)
            begin
                c_zero = 1'b1; c_zway = WB'(i);
            end
        end
        priority if (c_hit)   c_way = c_hway;
        else if (c_found)     c_way = c_iway;
        else if (c_zero)      c_way = c_zway;
        else                  c_way = '0;

        c_valid = rd_valid_reg;
        c_dirty = rd_dirty_reg;
        c_wb    = 1'b0;
        c_vaddr = '0;
        if (c_hit)
        begin
            if (act_reg == sac_pkg::ACT_WRITE) c_dirty[c_way] = 1'b1;
        end
        else
        begin
            if (rd_valid_reg[c_way] && rd_dirty_reg[c_way])
            begin
                c_wb    = 1'b1;
                c_vaddr = {rd_tag_reg[c_way], set_reg, OFF_BITS'(0)};
            end
            c_valid[c_way] = 1'b1;
            c_dirty[c_way] = (act_reg == sac_pkg::ACT_WRITE);
        end

        // age update
        old_age = rd_age_reg[c_way];
        c_age   = rd_age_reg;
        for (int i = 0; i < WAYS; i++)
        begin
            if (rd_age_reg[i] > old_age) c_age[i] = rd_age_reg[i] - 1'b1;
        end
        c_age[c_way] = WB'(WAYS - 1);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sac_pkg::ST_DECIDE)
        begin
            hit_reg    <= c_hit;
            way_reg    <= c_way;
            wb_reg     <= c_wb;
            vaddr_reg  <= c_vaddr;
            nvalid_reg <= c_valid;
            ndirty_reg <= c_dirty;
            nage_reg   <= c_age;
        end
    end

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign way            = way_reg;
    assign write_back     = wb_reg;
    assign victim_address = vaddr_reg;

    // checks
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == sac_pkg::ST_IDLE)
        else $error("pop outside idle");
    a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !q_pop)
        else $error("item taken during clear");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == sac_pkg::ST_DECIDE)
        else $error("result without decision");
    a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && write_back |-> !hit)
        else $error("write-back on hit");

endmodule

### rtl/set_assoc_cache_tag_lru_controller.sv
// Top level of the set-associative cache tag/valid/dirty/LRU controller.
// Instantiates sac_front and sac_back; depends on sac_pkg.
//
// Usage: drive action/address with start; the access is taken at a clock edge
// where start is high and busy is low. A front stage queues one decoded
// access while the back end works on the previous one.
// Each access gives one result: done pulses for one cycle with hit, way,
// write_back and victim_address valid. The receiver cannot stall.
// Sequence: while idle the back end takes the queued access, then it reads the
// set row, decides, and writes the row back; done rises with the decision registers.
// The back end takes a new access only while idle, so it completes one access
// (idle / read / decide / write) before it takes the next.
// Reset: a clearing pass zeroes the valid, dirty and age rows of every set in
// turn; tags need no clearing. One access may be taken during the pass; it waits
// in the front queue with busy high until the pass ends.
module set_assoc_cache_tag_lru_controller #(
    parameter int WAYS       = 8,
    parameter int SETS       = 256,
    parameter int LINE_BYTES = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    action,
    input  logic [31:0]             address,
    output logic                    done,
    output logic                    hit,
    output logic [$clog2(WAYS)-1:0] way,
    output logic                    write_back,
    output logic [31:0]             victim_address
);

    localparam int OFF_BITS = $clog2(LINE_BYTES);
    localparam int SET_BITS = $clog2(SETS);
    localparam int TAG_BITS = 32 - OFF_BITS - SET_BITS;

    logic                q_valid, q_action, q_pop;
    logic [SET_BITS-1:0] q_set;
    logic [TAG_BITS-1:0] q_tag;

    // decode and queue
    sac_front #(.SET_BITS(SET_BITS), .TAG_BITS(TAG_BITS), .OFF_BITS(OFF_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action), .address(address),
        .busy(busy), .q_valid(q_valid), .q_action(q_action), .q_set(q_set),
        .q_tag(q_tag), .q_pop(q_pop)
    );

    // lookup and update
    sac_back #(.WAYS(WAYS), .SET_BITS(SET_BITS), .TAG_BITS(TAG_BITS),
               .OFF_BITS(OFF_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_action(q_action),
        .q_set(q_set), .q_tag(q_tag), .q_pop(q_pop), .done(done), .hit(hit),
        .way(way), .write_back(write_back), .victim_address(victim_address)
    );

endmodule
